// File: rtl/wnm_pkg.sv
// Shared types, constants and the star-closure function of the wildcard name matcher.
package wnm_pkg;

    localparam int PATTERN_MAX   = 32;
    localparam int POS_W         = PATTERN_MAX + 1;
    localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
    localparam int CHAR_W        = 8;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int CHARS_PER_REG = CFG_DATA_W / CHAR_W;
    localparam int CHAR_SEL_W    = $clog2(CHARS_PER_REG);
    localparam int POS_IDX_W     = $clog2(PATTERN_MAX);

    localparam logic [CHAR_W-1:0] CH_ANY  = 8'h3F;  // '?'
    localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;  // '*'

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHARS_0,
        REG_CHARS_1,
        REG_CHARS_2,
        REG_CHARS_3,
        REG_LENGTH
    } cfg_reg_t;

    // Pattern summary handed from the config block to the matcher
    typedef struct packed {
        logic [PATTERN_MAX-1:0] star_mask;  // star at position, inside length
        logic [LEN_W-1:0]       len;        // saturated pattern length
        logic                   reclose;    // config written last cycle
    } pat_info_t;

    // Classified name character
    typedef struct packed {
        logic [PATTERN_MAX-1:0] adv;    // position consumes this character
        logic                   last;
        logic                   empty;
    } item_t;

    // Star closure: a live position in front of a star makes the next one live.
    // Runs of stars propagate like a carry chain, so one add does the whole pass.
    function automatic logic [POS_W-1:0] close_stars(input logic [POS_W-1:0] s,
                                                     input logic [PATTERN_MAX-1:0] m);
        logic [PATTERN_MAX-1:0] a;
        logic [POS_W-1:0]       sum;
        a   = s[PATTERN_MAX-1:0] & m;
        sum = {1'b0, a} + {1'b0, m};
        return s | (sum ^ {1'b0, a} ^ {1'b0, m});
    endfunction

endpackage

// File: rtl/wildcard_name_matcher_unit.sv
// Top level of the wildcard name matcher.
//
// Usage: load the pattern through the write port (cfg_we, cfg_index, cfg_wdata):
// indexes 0..3 hold pattern bytes 0..31, lowest byte first, index 4 the length.
// '*' matches any run of characters, '?' one character, other bytes themselves.
// Stream a name one byte per transaction on s_valid/s_ready; s_last marks the
// final byte, and an empty name is one transaction with s_empty_name and s_last
// set. Each last transaction yields one m_matched verdict on m_valid/m_ready.
// Path: an accepted byte is written into the queue and consumed from there by the
// back end, and a last byte's verdict is then held in the result register.
// Throughput: one byte per cycle unless the queue is held, set by the position
// update and its one-add star closure in the back end. After configuration writes,
// the first byte waits in the queue while the stored position set is re-closed.
// Reset clears the pattern to empty, the queue and the result register.
// When m_ready is low, non-last bytes keep flowing; a last byte waits in the
// two-entry queue until the result register frees, and s_ready drops once the
// queue is full.
module wildcard_name_matcher_unit
    import wnm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHAR_W-1:0]     s_name_char,
    input  logic                  s_last,
    input  logic                  s_empty_name,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_matched
);

    logic [PATTERN_MAX-1:0][CHAR_W-1:0] pattern;
    pat_info_t                          info;
    item_t                              front_item, q_item;
    logic                               q_full, q_valid, q_pop;

    // Pattern registers
    wnm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pattern   (pattern),
        .info      (info)
    );

    // Character classification
    wnm_front u_front (
        .name_char  (s_name_char),
        .last       (s_last),
        .empty_name (s_empty_name),
        .pattern    (pattern),
        .info       (info),
        .item       (front_item)
    );

    assign s_ready = !q_full;

    // Decoupling queue
    wnm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .wr_item   (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .rd_item   (q_item),
        .not_empty (q_valid)
    );

    // Matcher and result register
    wnm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .info      (info),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .pop       (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_matched (m_matched)
    );

endmodule

// File: rtl/wnm_cfg.sv
// Pattern configuration registers, length saturation and star mask.
module wnm_cfg
    import wnm_pkg::*;
(
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_wdata,
    output logic [PATTERN_MAX-1:0][CHAR_W-1:0] pattern,
    output pat_info_t                          info
);

    logic [PATTERN_MAX-1:0][CHAR_W-1:0] pattern_reg, pattern_next;
    logic [LEN_W-1:0]                   length_reg, length_next;
    logic                               reclose_reg;
    logic [LEN_W-1:0]                   len_eff;

    // Register write decode
    always_comb begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_CHARS_0, REG_CHARS_1, REG_CHARS_2, REG_CHARS_3: begin
                    for (int k = 0; k < CHARS_PER_REG; k++) begin
                        pattern_next[{cfg_index[POS_IDX_W-CHAR_SEL_W-1:0],
                                      CHAR_SEL_W'(k)}] = cfg_wdata[k*CHAR_W +: CHAR_W];
                    end
                end
                REG_LENGTH: begin
                    length_next = cfg_wdata[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= '0;
            reclose_reg <= 1'b0;
        end else begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            reclose_reg <= cfg_we;
        end
    end

    // Saturated length and star positions inside it
    assign len_eff = (length_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : length_reg;

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            info.star_mask[i] = (pattern_reg[i] == CH_STAR) && (LEN_W'(i) < len_eff);
        end
        info.len     = len_eff;
        info.reclose = reclose_reg;
    end

    assign pattern = pattern_reg;

endmodule

// File: rtl/wnm_front.sv
// Front end: compares a name character against every pattern position.
module wnm_front
    import wnm_pkg::*;
(
    input  logic [CHAR_W-1:0]                  name_char,
    input  logic                               last,
    input  logic                               empty_name,
    input  logic [PATTERN_MAX-1:0][CHAR_W-1:0] pattern,
    input  pat_info_t                          info,
    output item_t                              item
);

    // Literal or '?' match; stars never consume here
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            item.adv[i] = ((pattern[i] == name_char) || (pattern[i] == CH_ANY))
                          && (pattern[i] != CH_STAR) && (LEN_W'(i) < info.len);
        end
        item.last  = last;
        item.empty = empty_name;
    end

endmodule

// File: rtl/wnm_queue.sv
// Two-entry queue of classified characters between front and back.
module wnm_queue
    import wnm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t wr_item,
    output logic  full,
    input  logic  pop,
    output item_t rd_item,
    output logic  not_empty
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // Pointers and fill count
    always_comb begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assign rd_item   = mem_reg[rd_ptr_reg];
    assign full      = count_reg[1];
    assign not_empty = (count_reg != 2'd0);

endmodule

// File: rtl/wnm_back.sv
// Back end: position set update, star closure, verdict and result register.
module wnm_back
    import wnm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pat_info_t info,
    input  item_t     q_item,
    input  logic      q_valid,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output logic      m_matched
);

    logic [POS_W-1:0] state_reg, state_next;
    logic [POS_W-1:0] init_reg, init_next;
    logic             rearmed_reg, rearmed_next;
    logic             stale_reg, stale_next;
    logic             out_valid_reg, out_valid_next;
    logic             matched_reg, matched_next;
    logic [POS_W-1:0] stepped, closed;
    logic             verdict;
    logic             reclose_now;

    // One character step on the closed set, then close again
    assign stepped = {state_reg[PATTERN_MAX-1:0] & q_item.adv, 1'b0}
                   | {1'b0, state_reg[PATTERN_MAX-1:0] & info.star_mask};
    assign closed  = close_stars(stepped, info.star_mask);
    assign verdict = q_item.empty ? state_reg[info.len] : closed[info.len];

    // Re-close once, with the finished pattern, when the first character shows up
    assign reclose_now = stale_reg && q_valid && !info.reclose;

    // Hold while re-closing; a last item also needs room in the result register
    assign pop = q_valid && !stale_reg && !info.reclose
              && (!q_item.last || !out_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        init_next      = init_reg;
        rearmed_next   = rearmed_reg;
        stale_next     = stale_reg;
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;

        // Re-close stored sets after a pattern change
        if (info.reclose) begin
            stale_next = 1'b1;
        end else if (reclose_now) begin
            init_next  = close_stars(POS_W'(1), info.star_mask);
            state_next = rearmed_reg ? init_next : close_stars(state_reg, info.star_mask);
            stale_next = 1'b0;
        end else if (pop) begin
            if (q_item.last) begin
                state_next   = init_reg;
                rearmed_next = 1'b1;
            end else if (!q_item.empty) begin
                state_next   = closed;
                rearmed_next = 1'b0;
            end
        end

        // Result register
        if (pop && q_item.last) begin
            out_valid_next = 1'b1;
            matched_next   = verdict;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= POS_W'(1);
            init_reg      <= POS_W'(1);
            rearmed_reg   <= 1'b1;
            stale_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            rearmed_reg   <= rearmed_next;
            stale_reg     <= stale_next;
            out_valid_reg <= out_valid_next;
        end
        matched_reg <= matched_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_matched = matched_reg;

    // A rearmed matcher always holds the start position
    a_rearm_start: assert property (@(posedge aclk) disable iff (!aresetn)
        rearmed_reg |-> state_reg[0])
        else $error("rearmed state lost the start position");

    // A last character always produces a result
    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_item.last) |=> out_valid_reg)
        else $error("last transaction gave no result");

    // No character is consumed while the stored sets are out of date
    a_reclose_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (info.reclose || stale_reg) |-> !pop)
        else $error("character consumed while re-closing");

endmodule

// File: tb/wildcard_name_matcher_unit_tb.sv
// Self-checking testbench for the wildcard name matcher: glob verdicts per streamed name.
module wildcard_name_matcher_unit_tb;
    import wnm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 300;

    typedef logic [CHAR_W-1:0] name_q_t [$];
    typedef logic [CHAR_W-1:0] pat_arr_t [PATTERN_MAX];

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [CHAR_W-1:0]     s_name_char  = '0;
    logic                  s_last       = 1'b0;
    logic                  s_empty_name = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic                  m_matched;

    // Pattern registers and live position set as the matcher should hold them
    logic [CHAR_W-1:0] pat_bytes [PATTERN_MAX] = '{default: 8'h00};
    logic [5:0]        pat_len_cfg = '0;
    logic [POS_W-1:0]  live_pos    = POS_W'(1);

    logic verdicts_due [$];

    int src_idle_pct     = 20;
    int sink_idle_pct    = 65;
    int sink_hold_cycles = 0;
    int chars_sent       = 0;
    int verdicts_seen    = 0;
    int patterns_loaded  = 0;
    int mismatches       = 0;
    int quiet_cycles     = 0;

    wildcard_name_matcher_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_name_char  (s_name_char),
        .s_last       (s_last),
        .s_empty_name (s_empty_name),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_matched    (m_matched)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Glob predictor
    // ---------------------------------------------------------------------
    function automatic int pat_span();
        return (pat_len_cfg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_cfg);
    endfunction

    // a live position sitting on a star also makes the next one live
    function automatic logic [POS_W-1:0] star_closure(input logic [POS_W-1:0] s);
        int span;
        span = pat_span();
        for (int i = 0; i < span; i++) begin
            if (s[i] && pat_bytes[i] == CH_STAR) begin
                s[i+1] = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic void glob_step(input logic [CHAR_W-1:0] ch, input logic lst,
                                      input logic emp, output logic has_verdict,
                                      output logic verdict);
        logic [POS_W-1:0] cur;
        logic [POS_W-1:0] nxt;
        int               span;
        span        = pat_span();
        has_verdict = 1'b0;
        verdict     = 1'b0;
        cur         = star_closure(live_pos);
        if (!emp) begin
            nxt = '0;
            for (int i = 0; i < span; i++) begin
                if (cur[i]) begin
                    if (pat_bytes[i] == CH_STAR) begin
                        nxt[i] = 1'b1;
                    end else if (pat_bytes[i] == CH_ANY || pat_bytes[i] == ch) begin
                        nxt[i+1] = 1'b1;
                    end
                end
            end
            cur = star_closure(nxt);
        end else if (!lst) begin
            return;  // empty flag without last: ignored
        end
        if (lst) begin
            has_verdict = 1'b1;
            verdict     = cur[span];
            live_pos    = POS_W'(1);
        end else begin
            live_pos = cur;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Result side: ready pattern, checking, watchdog
    // ---------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_hold_cycles > 0) begin
            m_ready <= 1'b0;
            sink_hold_cycles = sink_hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // compare each verdict transaction against the oldest prediction
    always @(posedge aclk) begin
        logic want;
        if (aresetn && m_valid && m_ready) begin
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict %0b with no name pending", m_matched));
            end else begin
                want = verdicts_due.pop_front();
                if (m_matched !== want) begin
                    report_mismatch($sformatf("verdict %0d: matched got %0b want %0b",
                                              verdicts_seen, m_matched, want));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Drivers; every task starts and ends right after a rising edge
    // ---------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx <= REG_CHARS_3) begin
            for (int b = 0; b < CHARS_PER_REG; b++) begin
                pat_bytes[int'(idx) * CHARS_PER_REG + b] = data[CHAR_W*b +: CHAR_W];
            end
        end else if (idx == REG_LENGTH) begin
            pat_len_cfg = data[5:0];
        end
        @(posedge aclk);
    endtask

    task automatic load_pattern(input pat_arr_t p, input int len);
        logic [CFG_DATA_W-1:0] data;
        for (int k = 0; k < PATTERN_MAX / CHARS_PER_REG; k++) begin
            for (int b = 0; b < CHARS_PER_REG; b++) begin
                data[CHAR_W*b +: CHAR_W] = p[k*CHARS_PER_REG + b];
            end
            cfg_write(CFG_IDX_W'(int'(REG_CHARS_0) + k), data);
        end
        cfg_write(REG_LENGTH, CFG_DATA_W'(len));
        patterns_loaded++;
    endtask

    // unused tail bytes get junk so they are shown to be ignored
    task automatic load_pattern_str(input string s, input int len);
        pat_arr_t p;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            p[i] = (i < s.len()) ? s[i] : CHAR_W'($urandom_range(0, 255));
        end
        load_pattern(p, len);
    endtask

    // one input transaction, with random idle cycles in front
    task automatic send_item(input logic [CHAR_W-1:0] ch, input logic lst, input logic emp);
        logic has_verdict;
        logic verdict;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid      <= 1'b1;
        s_name_char  <= ch;
        s_last       <= lst;
        s_empty_name <= emp;
        do @(posedge aclk); while (s_ready !== 1'b1);
        glob_step(ch, lst, emp, has_verdict, verdict);
        if (has_verdict) begin
            verdicts_due = {verdicts_due, verdict};
        end
        if (!(emp && !lst)) begin
            chars_sent++;
        end
    endtask

    // stream a whole name; optionally end it on an empty item and sprinkle ignored items
    task automatic send_name(input name_q_t nm, input bit end_on_empty, input int noise_pct);
        if (nm.size() == 0) begin
            send_item(CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b1);
            return;
        end
        for (int i = 0; i < nm.size(); i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            send_item(nm[i], (i == nm.size() - 1) && !end_on_empty, 1'b0);
        end
        if (end_on_empty) begin
            send_item(CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
    endtask

    // stop sending, wait for every verdict, then let trailing bytes drain
    task automatic drain_results();
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------------
    // Random content
    // ---------------------------------------------------------------------
    function automatic name_q_t str_name(input string s);
        name_q_t nm;
        for (int i = 0; i < s.len(); i++) begin
            nm = {nm, s[i]};
        end
        return nm;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_name_char();
        string alphabet;
        alphabet = "abc.?*";
        if ($urandom_range(0, 99) < 70) begin
            return alphabet[$urandom_range(0, alphabet.len() - 1)];
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_pat_char();
        string alphabet;
        int    r;
        alphabet = "abc.";
        r        = $urandom_range(0, 99);
        if (r < 20) begin
            return CH_STAR;
        end else if (r < 35) begin
            return CH_ANY;
        end else if (r < 90) begin
            return alphabet[$urandom_range(0, alphabet.len() - 1)];
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // a name that fits the current pattern, then maybe damaged
    function automatic name_q_t fitting_name();
        name_q_t nm;
        int      pos;
        for (int i = 0; i < pat_span(); i++) begin
            if (pat_bytes[i] == CH_STAR) begin
                repeat ($urandom_range(0, 3)) nm = {nm, pick_name_char()};
            end else if (pat_bytes[i] == CH_ANY) begin
                nm = {nm, pick_name_char()};
            end else begin
                nm = {nm, pat_bytes[i]};
            end
        end
        if ($urandom_range(0, 99) < 30) begin
            if (nm.size() == 0) begin
                nm = {nm, pick_name_char()};
            end else begin
                pos = $urandom_range(0, nm.size() - 1);
                case ($urandom_range(0, 2))
                    0: nm[pos] = pick_name_char();
                    1: nm.delete(pos);
                    default: nm.insert(pos, pick_name_char());
                endcase
            end
        end
        return nm;
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // hand-picked names: operators, byte extremes, empty-name forms,
    // saturated length, ignored register indexes, pattern change mid-name
    task automatic test_directed();
        name_q_t  nm;
        pat_arr_t stars;
        // reset pattern is empty: only the empty name matches
        send_name(nm, 1'b0, 0);
        nm = str_name("a");
        send_name(nm, 1'b0, 0);

        drain_results();
        load_pattern_str("a?c*", 4);
        nm = str_name("abc");
        send_name(nm, 1'b0, 0);
        nm = '{8'h61, 8'hFF, 8'h63, 8'h00};
        send_name(nm, 1'b0, 0);
        // ignored empties inside, verdict given by the closing empty item
        nm = str_name("ab");
        send_name(nm, 1'b1, 100);

        // all stars with the length past the maximum
        drain_results();
        foreach (stars[i]) stars[i] = CH_STAR;
        load_pattern(stars, 63);
        nm.delete();
        send_name(nm, 1'b0, 0);
        nm = '{8'h7A};
        send_name(nm, 1'b0, 0);

        // writes to unused indexes must leave the pattern alone
        drain_results();
        for (int k = int'(REG_LENGTH) + 1; k < (1 << CFG_IDX_W); k++) begin
            cfg_write(CFG_IDX_W'(k), {$urandom(), $urandom()});
        end
        nm.delete();
        send_name(nm, 1'b0, 0);

        // new pattern picks up the live positions left by the old one
        drain_results();
        load_pattern_str("ab", 2);
        send_item("a", 1'b0, 1'b0);
        drain_results();
        load_pattern_str("x*", 2);
        send_item("z", 1'b1, 1'b0);

        // shrink the length under a half-matched name
        drain_results();
        load_pattern_str("abcd", 4);
        nm = str_name("abc");
        foreach (nm[i]) send_item(nm[i], 1'b0, 1'b0);
        drain_results();
        cfg_write(REG_LENGTH, CFG_DATA_W'(3));
        send_item(8'h00, 1'b1, 1'b1);
        foreach (nm[i]) send_item(nm[i], 1'b0, 1'b0);
        drain_results();
        cfg_write(REG_LENGTH, CFG_DATA_W'(2));
        send_item("q", 1'b1, 1'b0);
        drain_results();
    endtask

    // random patterns, mostly fitting names, some noise and unfinished names
    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int budget);
        pat_arr_t p;
        name_q_t  nm;
        int       stop_at;
        int       len;
        int       r;
        src_idle_pct  = src_pct;
        sink_idle_pct = snk_pct;
        stop_at       = chars_sent + budget;
        while (chars_sent < stop_at) begin
            // sometimes leave a name open across the pattern change
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_item(pick_name_char(), 1'b0, 1'b0);
            end
            drain_results();
            foreach (p[i]) p[i] = pick_pat_char();
            r = $urandom_range(0, 99);
            if (r < 5) begin
                len = 0;
            end else if (r < 10) begin
                len = PATTERN_MAX;
            end else if (r < 14) begin
                len = $urandom_range(PATTERN_MAX + 1, 63);
            end else begin
                len = $urandom_range(1, 10);
            end
            load_pattern(p, len);
            repeat ($urandom_range(8, 16)) begin
                r = $urandom_range(0, 99);
                nm.delete();
                if (r < 60) begin
                    nm = fitting_name();
                end else if (r < 90) begin
                    repeat ($urandom_range(1, 8)) nm = {nm, pick_name_char()};
                end
                send_name(nm, $urandom_range(0, 9) == 0,
                          ($urandom_range(0, 4) == 0) ? 5 : 0);
            end
        end
        drain_results();
    endtask

    // receiver holds off while short names pile up and the input stalls
    task automatic test_result_stall();
        name_q_t nm;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        drain_results();
        load_pattern_str("?*b", 3);
        sink_hold_cycles = HOLD_CYCLES;
        repeat (40) begin
            nm.delete();
            repeat ($urandom_range(1, 3)) nm = {nm, pick_name_char()};
            send_name(nm, 1'b0, 0);
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(20, 65, 300);
        test_random_traffic(65, 20, 300);
        test_result_stall();
        test_random_traffic(0, 0, 300);
        drain_results();

        $display("covered %0d name characters, %0d verdicts over %0d patterns",
                 chars_sent, verdicts_seen, patterns_loaded);
        $display("incl. saturated length, mid-name pattern changes and a %0d-cycle result stall",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
